@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JL2_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jl2 assertion failed");

// Next-cycle implication, checked outside reset.
`define JL2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jl2 assertion failed");

`endif

@@ sv/jl2_pkg.sv @@
package jl2_pkg;

    localparam logic [31:0] GOLDEN_RATIO    = 32'h9e3779b9;
    localparam int          BUCKET_W        = 20;
    localparam logic [4:0]  MAX_BUCKET_BITS = 5'd20;
    localparam logic [4:0]  BUCKET_BITS_RST = 5'd16;
    localparam int          JL2_QUEUE_DEPTH = 4;
    localparam int          CFG_INDEX_W     = 1;

    // shift amounts of the nine mix rows, three per pipeline stage
    localparam int MIX_SH_A0 = 13;
    localparam int MIX_SH_B0 = 8;
    localparam int MIX_SH_C0 = 13;
    localparam int MIX_SH_A1 = 12;
    localparam int MIX_SH_B1 = 16;
    localparam int MIX_SH_C1 = 5;
    localparam int MIX_SH_A2 = 3;
    localparam int MIX_SH_B2 = 10;
    localparam int MIX_SH_C2 = 15;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HASH_SEED,
        REG_BUCKET_BITS
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SLOT_A,
        SLOT_B,
        SLOT_C
    } slot_t;

    typedef enum logic [1:0] {
        OP_ACC,
        OP_GROUP,
        OP_FINAL
    } op_kind_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } acc3_t;

    typedef struct packed {
        op_kind_t kind;
        acc3_t    addend;
    } queue_entry_t;

    typedef struct packed {
        logic [31:0] key_word;
        logic [2:0]  word_bytes;
        logic        last_word;
    } key_item_t;

    typedef struct packed {
        logic [31:0]         hash_value;
        logic [BUCKET_W-1:0] bucket_index;
    } result_item_t;

    typedef struct packed {
        cfg_reg_t    index;
        logic [31:0] value;
    } cfg_write_t;

    function automatic acc3_t mix_third(acc3_t s, int unsigned sh_a, int unsigned sh_b,
                                        int unsigned sh_c);
        acc3_t r;
        r   = s;
        r.a = (r.a - r.b - r.c) ^ (r.c >> sh_a);
        r.b = (r.b - r.c - r.a) ^ (r.a << sh_b);
        r.c = (r.c - r.a - r.b) ^ (r.b >> sh_c);
        return r;
    endfunction

    function automatic logic [BUCKET_W-1:0] bucket_mask(logic [4:0] bits);
        logic [4:0]        b;
        logic [BUCKET_W:0] m;
        b = (bits > MAX_BUCKET_BITS) ? MAX_BUCKET_BITS : bits;
        m = ((BUCKET_W+1)'(1) << b) - (BUCKET_W+1)'(1);
        return m[BUCKET_W-1:0];
    endfunction

endpackage

@@ sv/jl2_stream_if.sv @@
interface jl2_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/jenkins_lookup2_hash.sv @@
// Streaming lookup2 hash: takes one key word per clock while the input queue has room and
// returns the 32-bit hash and its bucket index after the last word. The mix runs in a
// three-stage pipeline of three rows each, so a group's mix is back exactly when the next
// 12-byte group is complete and long keys stream at one word per cycle when nothing stalls.
// A last word that arrives before its group's mix is back waits in the input queue for
// that mix; a full last word in the third slot holds the input while a closing entry with
// the length is pushed, as that key is mixed twice at its end. Different keys overlap in
// the pipeline. The result passes through the queue, the mix stages and an output register.
`include "assert_macros.svh"

module jenkins_lookup2_hash import jl2_pkg::*;
#(
    parameter int QUEUE_DEPTH = JL2_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    jl2_stream_if.sink   key,
    jl2_stream_if.source result,
    jl2_stream_if.sink   cfg
);

    logic [31:0]  seed_reg, seed_next;
    logic [4:0]   bucket_bits_reg, bucket_bits_next;

    logic         q_push;
    logic         q_ready;
    logic         q_pop;
    logic         q_valid;
    queue_entry_t q_in;
    queue_entry_t q_out;

    logic [BUCKET_W-1:0] bucket_chk;

    always_comb
    begin
        cfg.ready        = 1'b1;
        seed_next        = seed_reg;
        bucket_bits_next = bucket_bits_reg;
        if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_HASH_SEED:   seed_next        = cfg.data.value;
                REG_BUCKET_BITS: bucket_bits_next = cfg.data.value[4:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= '0;
            bucket_bits_reg <= BUCKET_BITS_RST;
        end
        else
        begin
            seed_reg        <= seed_next;
            bucket_bits_reg <= bucket_bits_next;
        end
    end

    jl2_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .key     (key),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    jl2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    jl2_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_out),
        .q_pop       (q_pop),
        .seed        (seed_reg),
        .bucket_bits (bucket_bits_reg),
        .result      (result)
    );

    assign bucket_chk = result.data.hash_value[BUCKET_W-1:0] & bucket_mask(bucket_bits_reg);

    `JL2_ASSERT_IMPLIES(a_pop_nonempty, q_pop, q_valid)
    `JL2_ASSERT_IMPLIES(a_push_room, q_push, q_ready)
    `JL2_ASSERT_IMPLIES(a_bucket_mask, result.valid, result.data.bucket_index == bucket_chk)

endmodule

@@ sv/jl2_front.sv @@
module jl2_front import jl2_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    jl2_stream_if.sink   key,
    input  logic         q_ready,
    output logic         q_push,
    output queue_entry_t q_entry
);

    slot_t       slot_reg, slot_next;
    logic [31:0] total_reg, total_next;
    logic        pend_reg, pend_next;
    logic [31:0] pend_total_reg, pend_total_next;

    logic [2:0]  n_sat;
    logic [2:0]  n_eff;
    logic [31:0] total_sum;
    logic [31:0] tail;
    logic [31:0] lane_word;
    logic        last;
    logic        mix_first;
    logic        accept;

    always_comb
    begin
        last      = key.data.last_word;
        n_sat     = (key.data.word_bytes > 3'd4) ? 3'd4 : key.data.word_bytes;
        n_eff     = last ? n_sat : 3'd4;
        total_sum = total_reg + 32'(n_eff);
        mix_first = last && (n_sat == 3'd4) && (slot_reg == SLOT_C);

        unique case (n_sat)
            3'd0:    tail = '0;
            3'd1:    tail = {24'd0, key.data.key_word[7:0]};
            3'd2:    tail = {16'd0, key.data.key_word[15:0]};
            3'd3:    tail = {8'd0, key.data.key_word[23:0]};
            default: tail = key.data.key_word;
        endcase

        if (!last)
        begin
            lane_word = key.data.key_word;
        end
        else if (slot_reg == SLOT_C && !mix_first)
        begin
            lane_word = tail << 8;
        end
        else
        begin
            lane_word = tail;
        end

        q_entry.addend = '0;
        unique case (slot_reg)
            SLOT_A:  q_entry.addend.a = lane_word;
            SLOT_B:  q_entry.addend.b = lane_word;
            SLOT_C:  q_entry.addend.c = lane_word;
            default: q_entry.addend   = '0;
        endcase

        if (!last)
        begin
            q_entry.kind = (slot_reg == SLOT_C) ? OP_GROUP : OP_ACC;
        end
        else if (mix_first)
        begin
            q_entry.kind = OP_GROUP;
        end
        else
        begin
            q_entry.kind     = OP_FINAL;
            q_entry.addend.c = q_entry.addend.c + total_sum;
        end

        // full last word in slot C: closing pass with the length only
        if (pend_reg)
        begin
            q_entry.kind   = OP_FINAL;
            q_entry.addend = '{a: '0, b: '0, c: pend_total_reg};
        end

        key.ready = q_ready && !pend_reg;
        q_push    = q_ready && (pend_reg || key.valid);
        accept    = key.valid && key.ready;

        slot_next       = slot_reg;
        total_next      = total_reg;
        pend_next       = pend_reg;
        pend_total_next = pend_total_reg;

        if (pend_reg && q_ready)
        begin
            pend_next = 1'b0;
        end

        if (accept)
        begin
            if (last)
            begin
                slot_next       = SLOT_A;
                total_next      = '0;
                pend_next       = mix_first;
                pend_total_next = total_sum;
            end
            else
            begin
                total_next = total_sum;
                unique case (slot_reg)
                    SLOT_A:  slot_next = SLOT_B;
                    SLOT_B:  slot_next = SLOT_C;
                    default: slot_next = SLOT_A;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= SLOT_A;
            total_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_total_reg <= pend_total_next;
    end

endmodule

@@ sv/jl2_queue.sv @@
module jl2_queue import jl2_pkg::*;
#(
    parameter int DEPTH = JL2_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_data,
    output logic         ready,
    input  logic         pop,
    output logic         valid,
    output queue_entry_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    always_comb
    begin
        ready    = (count_reg != CNT_W'(DEPTH));
        valid    = (count_reg != '0);
        pop_data = mem_reg[rd_ptr_reg];
        push_ok  = push && ready;
        pop_ok   = pop && valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push_ok) - CNT_W'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/jl2_back.sv @@
module jl2_back import jl2_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  queue_entry_t q_entry,
    output logic         q_pop,
    input  logic [31:0]  seed,
    input  logic [4:0]   bucket_bits,
    jl2_stream_if.source result
);

    acc3_t        base_reg, base_next;
    acc3_t        part_reg, part_next;
    logic         fresh_reg, fresh_next;
    logic         busy_reg, busy_next;

    acc3_t        s1_reg, s1_next;
    acc3_t        s2_reg, s2_next;
    acc3_t        s3_reg, s3_next;
    logic         s1_valid_reg, s1_valid_next;
    logic         s2_valid_reg, s2_valid_next;
    logic         s3_valid_reg, s3_valid_next;
    logic         s1_fin_reg, s1_fin_next;
    logic         s2_fin_reg, s2_fin_next;
    logic         s3_fin_reg, s3_fin_next;

    logic         out_valid_reg, out_valid_next;
    result_item_t out_item_reg, out_item_next;

    acc3_t        init_acc;
    acc3_t        base_eff;
    acc3_t        sum;
    logic         ret;
    logic         out_free;
    logic         adv;
    logic         is_acc;

    always_comb
    begin
        init_acc = '{a: GOLDEN_RATIO, b: GOLDEN_RATIO, c: seed};
        ret      = s3_valid_reg && !s3_fin_reg;
        out_free = !out_valid_reg || result.ready;
        adv      = !(s3_valid_reg && s3_fin_reg) || out_free;

        if (fresh_reg)
        begin
            base_eff = init_acc;
        end
        else if (ret)
        begin
            base_eff = s3_reg;
        end
        else
        begin
            base_eff = base_reg;
        end

        sum.a = base_eff.a + part_reg.a + q_entry.addend.a;
        sum.b = base_eff.b + part_reg.b + q_entry.addend.b;
        sum.c = base_eff.c + part_reg.c + q_entry.addend.c;

        is_acc = (q_entry.kind == OP_ACC);
        q_pop  = q_valid && adv && (is_acc || !busy_reg || ret);

        s1_next       = mix_third(sum, MIX_SH_A0, MIX_SH_B0, MIX_SH_C0);
        s2_next       = mix_third(s1_reg, MIX_SH_A1, MIX_SH_B1, MIX_SH_C1);
        s3_next       = mix_third(s2_reg, MIX_SH_A2, MIX_SH_B2, MIX_SH_C2);
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s3_valid_next = s3_valid_reg;
        s1_fin_next   = s1_fin_reg;
        s2_fin_next   = s2_fin_reg;
        s3_fin_next   = s3_fin_reg;

        base_next  = base_reg;
        part_next  = part_reg;
        fresh_next = fresh_reg;
        busy_next  = busy_reg;

        if (adv)
        begin
            s1_valid_next = q_pop && !is_acc;
            s1_fin_next   = (q_entry.kind == OP_FINAL);
            s2_valid_next = s1_valid_reg;
            s2_fin_next   = s1_fin_reg;
            s3_valid_next = s2_valid_reg;
            s3_fin_next   = s2_fin_reg;

            if (ret)
            begin
                base_next = s3_reg;
                busy_next = 1'b0;
            end

            if (q_pop)
            begin
                unique case (q_entry.kind)
                    OP_ACC:
                    begin
                        part_next.a = part_reg.a + q_entry.addend.a;
                        part_next.b = part_reg.b + q_entry.addend.b;
                        part_next.c = part_reg.c + q_entry.addend.c;
                    end
                    OP_GROUP:
                    begin
                        part_next  = '0;
                        busy_next  = 1'b1;
                        fresh_next = 1'b0;
                    end
                    OP_FINAL:
                    begin
                        part_next  = '0;
                        busy_next  = 1'b0;
                        fresh_next = 1'b1;
                    end
                    default:
                    begin
                        part_next = part_reg;
                    end
                endcase
            end
        end

        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_free)
        begin
            out_valid_next             = s3_valid_reg && s3_fin_reg;
            out_item_next.hash_value   = s3_reg.c;
            out_item_next.bucket_index = s3_reg.c[BUCKET_W-1:0] & bucket_mask(bucket_bits);
        end

        result.valid = out_valid_reg;
        result.data  = out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg      <= '0;
            fresh_reg     <= 1'b1;
            busy_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            part_reg      <= part_next;
            fresh_reg     <= fresh_next;
            busy_reg      <= busy_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        out_item_reg <= out_item_next;
        s1_fin_reg   <= s1_fin_next;
        s2_fin_reg   <= s2_fin_next;
        s3_fin_reg   <= s3_fin_next;
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

endmodule

@@ tb/tb_jenkins_lookup2_hash.sv @@
`timescale 1ns / 100ps

import jl2_pkg::*;

class hash_scoreboard;
    logic [31:0]  seed;
    logic [4:0]   bucket_bits;
    logic [31:0]  acc_a;
    logic [31:0]  acc_b;
    logic [31:0]  acc_c;
    slot_t        slot;
    logic [31:0]  byte_total;
    result_item_t expected_q[$];
    int           errors;

    function new();
        seed        = '0;
        bucket_bits = BUCKET_BITS_RST;
        errors      = 0;
        restart_key();
    endfunction

    function void restart_key();
        acc_a      = GOLDEN_RATIO;
        acc_b      = GOLDEN_RATIO;
        acc_c      = seed;
        slot       = SLOT_A;
        byte_total = '0;
    endfunction

    function void mix_accs();
        acc_a = (acc_a - acc_b - acc_c) ^ (acc_c >> 13);
        acc_b = (acc_b - acc_c - acc_a) ^ (acc_a << 8);
        acc_c = (acc_c - acc_a - acc_b) ^ (acc_b >> 13);
        acc_a = (acc_a - acc_b - acc_c) ^ (acc_c >> 12);
        acc_b = (acc_b - acc_c - acc_a) ^ (acc_a << 16);
        acc_c = (acc_c - acc_a - acc_b) ^ (acc_b >> 5);
        acc_a = (acc_a - acc_b - acc_c) ^ (acc_c >> 3);
        acc_b = (acc_b - acc_c - acc_a) ^ (acc_a << 10);
        acc_c = (acc_c - acc_a - acc_b) ^ (acc_b >> 15);
    endfunction

    function void add_to_slot(logic [31:0] v);
        case (slot)
            SLOT_A:  acc_a = acc_a + v;
            SLOT_B:  acc_b = acc_b + v;
            default: acc_c = acc_c + v;
        endcase
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] value);
        case (idx)
            REG_HASH_SEED:
            begin
                seed = value;
                if (slot == SLOT_A && byte_total == 0)
                    acc_c = seed;
            end
            REG_BUCKET_BITS: bucket_bits = value[4:0];
            default: ;
        endcase
    endfunction

    function void note_key(key_item_t item);
        logic [2:0]   nbytes;
        logic [31:0]  tail;
        logic [4:0]   bits;
        logic [31:0]  mask;
        result_item_t res;
        if (!item.last_word)
        begin
            add_to_slot(item.key_word);
            byte_total = byte_total + 32'd4;
            if (slot == SLOT_C)
            begin
                mix_accs();
                slot = SLOT_A;
            end
            else
                slot = slot_t'(slot + 1);
            return;
        end
        nbytes     = (item.word_bytes > 3'd4) ? 3'd4 : item.word_bytes;
        byte_total = byte_total + 32'(nbytes);
        if (nbytes == 3'd4 && slot == SLOT_C)
        begin
            acc_c = acc_c + item.key_word;
            mix_accs();
        end
        else if (nbytes != 0)
        begin
            if (nbytes == 3'd4)
                tail = item.key_word;
            else
                tail = item.key_word & ((32'd1 << (8 * nbytes)) - 32'd1);
            if (slot == SLOT_C)
                tail = tail << 8;
            add_to_slot(tail);
        end
        acc_c = acc_c + byte_total;
        mix_accs();
        bits             = (bucket_bits > 5'd20) ? 5'd20 : bucket_bits;
        mask             = (32'd1 << bits) - 32'd1;
        res.hash_value   = acc_c;
        res.bucket_index = acc_c[BUCKET_W-1:0] & mask[BUCKET_W-1:0];
        expected_q.push_back(res);
        restart_key();
    endfunction

    function void check_result(result_item_t got);
        result_item_t exp;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result: hash_value %h, bucket_index %h",
                   got.hash_value, got.bucket_index);
            errors++;
            return;
        end
        exp = expected_q.pop_front();
        if (got.hash_value !== exp.hash_value)
        begin
            $error("hash_value: expected %h, got %h", exp.hash_value, got.hash_value);
            errors++;
        end
        if (got.bucket_index !== exp.bucket_index)
        begin
            $error("bucket_index: expected %h, got %h", exp.bucket_index, got.bucket_index);
            errors++;
        end
    endfunction
endclass

module tb_jenkins_lookup2_hash;
    import jl2_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int ITEMS_PER_PH = 100;

    logic clk;
    logic rst_n;
    bit   steady;
    int   words_sent;

    hash_scoreboard sb;

    jl2_stream_if #(.T(key_item_t))    key_if ();
    jl2_stream_if #(.T(result_item_t)) result_if ();
    jl2_stream_if #(.T(cfg_write_t))   cfg_if ();

    jenkins_lookup2_hash dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready <= steady || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.data);
            if (key_if.valid && key_if.ready)
                sb.note_key(key_if.data);
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.data.index, cfg_if.data.value);
        end
    end

    // gives up after a long stretch with no transfer on any channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((key_if.valid && key_if.ready) || (result_if.valid && result_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_jenkins_lookup2_hash failed");
        $finish;
    end

    task automatic send_word(logic [31:0] w, logic [2:0] nbytes, logic lastw);
        key_item_t item;
        item.key_word   = w;
        item.word_bytes = nbytes;
        item.last_word  = lastw;
        while (!steady && $urandom_range(0, 99) < 35)
        begin
            key_if.valid <= 1'b0;
            @(negedge clk);
        end
        key_if.data  <= item;
        key_if.valid <= 1'b1;
        @(posedge clk);
        while (!key_if.ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_key(int body_words);
        for (int i = 0; i < body_words; i++)
            send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    task automatic set_config(logic [31:0] seed_val, logic [31:0] bits_val);
        cfg_write_t wr;
        wr.index = REG_HASH_SEED;
        wr.value = seed_val;
        cfg_if.data  <= wr;
        cfg_if.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        wr.index = REG_BUCKET_BITS;
        wr.value = bits_val;
        cfg_if.data <= wr;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // wait for every pending hash, then let the pipeline settle
    task automatic drain();
        key_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    initial
    begin
        int target;
        sb           = new();
        words_sent   = 0;
        steady       = 1'b0;
        rst_n        = 1'b0;
        key_if.valid = 1'b0;
        key_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty key, then one-word keys of every length incl. an oversized count
        send_word(32'hffffffff, 3'd0, 1'b1);
        send_word(32'hffffffff, 3'd1, 1'b1);
        send_word(32'h00000000, 3'd2, 1'b1);
        send_word(32'hffffffff, 3'd3, 1'b1);
        send_word(32'hffffffff, 3'd4, 1'b1);
        send_word(32'h12345678, 3'd7, 1'b1);
        // tail in second slot; count on a body word is ignored
        send_word(32'h00000000, 3'd0, 1'b0);
        send_word(32'hffffffff, 3'd3, 1'b1);
        // tail in third slot, shifted up
        send_word(32'hffffffff, 3'd7, 1'b0);
        send_word(32'h00000000, 3'd1, 1'b0);
        send_word(32'hffffffff, 3'd2, 1'b1);
        // full last word closes a group
        send_word(32'hffffffff, 3'd4, 1'b0);
        send_word(32'hffffffff, 3'd4, 1'b0);
        send_word(32'hffffffff, 3'd4, 1'b1);
        send_word(32'h00000000, 3'd2, 1'b0);
        send_word(32'h80000001, 3'd5, 1'b0);
        send_word(32'hdeadbeef, 3'd6, 1'b1);
        // full group followed by an empty last word
        send_word(32'h01020304, 3'd0, 1'b0);
        send_word(32'h05060708, 3'd0, 1'b0);
        send_word(32'h090a0b0c, 3'd0, 1'b0);
        send_word(32'hffffffff, 3'd0, 1'b1);
        drain();

        for (int ph = 1; ph < 8; ph++)
        begin
            case (ph)
                1: set_config(32'hffffffff, 32'd0);
                2: set_config($urandom, 32'd20);
                3: set_config(32'h00000000, 32'd31);
                4: set_config($urandom, 32'd21);
                default: set_config($urandom, $urandom);
            endcase
            steady = (ph == 2);
            target = words_sent + ITEMS_PER_PH;
            while (words_sent < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_key($urandom_range(12, 40));
                else
                    send_key($urandom_range(0, 8));
            end
            drain();
            steady = 1'b0;
        end

        repeat (20) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            $error("%0d hash results never arrived", sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb_jenkins_lookup2_hash passed");
        else
            $display("tb_jenkins_lookup2_hash failed");
        $finish;
    end
endmodule
